[rtl/core/complex_arith_unit_core_macros.svh]
// Assertion macros shared by the core files.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef COMPLEX_ARITH_UNIT_CORE_MACROS_SVH
`define COMPLEX_ARITH_UNIT_CORE_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define CAU_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
// next-cycle implication
`define CAU_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define CAU_ASSERT_IMP(lbl, ante, cons, msg)
`define CAU_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

[rtl/core/cau_pkg.sv]
package cau_pkg;

  // word format
  localparam int WB    = 32;          // word bits
  localparam int FB    = 16;          // fraction bits
  localparam int DW    = 2 * WB;      // product / divisor width
  localparam int SW    = DW + 1;      // signed sum width
  localparam int QB    = WB + 1;      // quotient bits produced by the chain
  localparam int NW    = DW + FB;     // shifted numerator width
  localparam int HW    = NW - QB;     // numerator bits above the chain
  localparam int NCELL = QB;          // one divide cell per quotient bit

  localparam logic [WB-1:0] W_MAX = {1'b0, {(WB-1){1'b1}}};
  localparam logic [WB-1:0] W_MIN = {1'b1, {(WB-1){1'b0}}};

  // operation codes
  localparam logic [1:0] CMD_ADD = 2'd0;
  localparam logic [1:0] CMD_SUB = 2'd1;
  localparam logic [1:0] CMD_MUL = 2'd2;
  localparam logic [1:0] CMD_DIV = 2'd3;

  // status codes
  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_DZ  = 2'd1;
  localparam logic [1:0] ST_OVF = 2'd2;

  typedef struct packed {
    logic [WB-1:0] val;
    logic          ovf;
  } sat_t;

  // item travelling down the divide chain
  typedef struct packed {
    logic          div;      // result still to be formed from the quotient
    logic [WB-1:0] res_re;   // finished result when div is low
    logic [WB-1:0] res_im;
    logic [1:0]    status;
    logic          neg_re;
    logic          neg_im;
    logic          big_re;   // quotient known to exceed the chain's reach
    logic          big_im;
    logic [DW-1:0] den;
    logic [DW-1:0] rem_re;
    logic [DW-1:0] rem_im;
    logic [QB-1:0] num_re;   // numerator bits in, quotient bits out
    logic [QB-1:0] num_im;
  } lane_t;

  // sign and magnitude to a saturated word
  function automatic sat_t sat_word(input logic neg, input logic [DW-1:0] mag);
    logic [DW-1:0] lim;
    logic [DW-1:0] v;
    sat_t          s;
    lim   = neg ? (DW'(1) << (WB - 1)) : ((DW'(1) << (WB - 1)) - DW'(1));
    s.ovf = mag > lim;
    v     = s.ovf ? lim : mag;
    s.val = neg ? (~v[WB-1:0] + WB'(1)) : v[WB-1:0];
    return s;
  endfunction

endpackage

[rtl/core/complex_arith_unit_core.sv]
// Channel   Ports                                       Direction
// --------  ------------------------------------------  ---------
// input     in_valid/in_ready, in_cmd, in_a_*, in_b_*   in
// result    out_valid/out_ready, out_real/imag/status   out
//
// One item per cycle sustained while out_ready stays high; every operation passes
// through four front stages (products, sums, magnitudes, chain set-up), 33 divide
// cells (one quotient bit each) and the output register.
// Reset clears only valid bits. Each stage holds while its successor is full
// and stalled, so bubbles close up and a waiting result does not block input.
`include "complex_arith_unit_core_macros.svh"

module complex_arith_unit_core
  import cau_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           in_cmd,
  input  logic signed [WB-1:0] in_a_real,
  input  logic signed [WB-1:0] in_a_imag,
  input  logic signed [WB-1:0] in_b_real,
  input  logic signed [WB-1:0] in_b_imag,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic signed [WB-1:0] out_real,
  output logic signed [WB-1:0] out_imag,
  output logic [1:0]           out_status
);

  logic  chain_v   [0:NCELL];
  logic  chain_rdy [0:NCELL];
  lane_t chain_d   [0:NCELL];

  cau_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_cmd    (in_cmd),
    .in_a_real (in_a_real),
    .in_a_imag (in_a_imag),
    .in_b_real (in_b_real),
    .in_b_imag (in_b_imag),
    .out_valid (chain_v[0]),
    .out_ready (chain_rdy[0]),
    .out_data  (chain_d[0])
  );

  // divide chain, one cell per quotient bit
  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    cau_div_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (chain_v[i]),
      .in_ready  (chain_rdy[i]),
      .in_data   (chain_d[i]),
      .out_valid (chain_v[i+1]),
      .out_ready (chain_rdy[i+1]),
      .out_data  (chain_d[i+1])
    );
  end

  cau_tail u_tail (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (chain_v[NCELL]),
    .in_ready   (chain_rdy[NCELL]),
    .in_data    (chain_d[NCELL]),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_real   (out_real),
    .out_imag   (out_imag),
    .out_status (out_status)
  );

  // result checks
  `CAU_ASSERT_IMP(a_dz_zero, out_valid && out_status == ST_DZ, out_real == '0 && out_imag == '0, "divide by zero result not zero")
  `CAU_ASSERT_IMP(a_st_code, out_valid, out_status == ST_OK || out_status == ST_DZ || out_status == ST_OVF, "undefined status")
  `CAU_ASSERT_IMP(a_ovf_lim, out_valid && out_status == ST_OVF, out_real == W_MAX || out_real == W_MIN || out_imag == W_MAX || out_imag == W_MIN, "overflow without a limit value")

endmodule

[rtl/core/cau_front.sv]
module cau_front
  import cau_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           in_cmd,
  input  logic signed [WB-1:0] in_a_real,
  input  logic signed [WB-1:0] in_a_imag,
  input  logic signed [WB-1:0] in_b_real,
  input  logic signed [WB-1:0] in_b_imag,
  output logic                 out_valid,
  input  logic                 out_ready,
  output lane_t                out_data
);

  logic v1_r, v2_r, v3_r, v4_r;
  logic en1, en2, en3, en4;

  // stage 1: products and plain sums
  logic [1:0]           cmd1_r;
  logic                 dz1_r;
  logic signed [DW-1:0] p_rr_r, p_ii_r, p_ri_r, p_ir_r, p_bb_r, p_cc_r;
  logic signed [WB:0]   s_re_r, s_im_r;

  // stage 2: combined sums
  logic [1:0]           cmd2_r;
  logic                 dz2_r;
  logic signed [SW-1:0] t_re_r, t_im_r;
  logic signed [SW-1:0] t_re_nxt, t_im_nxt;
  logic [DW-1:0]        z2_r;

  // stage 3: sign and magnitude
  logic [1:0]    cmd3_r;
  logic          dz3_r;
  logic          neg_re_r, neg_im_r;
  logic [DW-1:0] mag_re_r, mag_im_r, z3_r;
  logic [SW-1:0] nm_re, nm_im;

  // stage 4: chain entry
  lane_t         l4_r, l4_nxt;
  logic [NW-1:0] n_re, n_im;
  logic [HW-1:0] hi_re, hi_im;
  sat_t          sre, sim;

  // stall chain, a stage moves when it is empty or its successor moves
  assign en4      = !v4_r || out_ready;
  assign en3      = !v3_r || en4;
  assign en2      = !v2_r || en3;
  assign en1      = !v1_r || en2;
  assign in_ready = en1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_valid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
      if (en4) v4_r <= v3_r;
    end
  end

  // stage 1
  always_ff @(posedge clk) begin
    if (en1 && in_valid) begin
      cmd1_r <= in_cmd;
      dz1_r  <= (in_b_real == '0) && (in_b_imag == '0);
      p_rr_r <= DW'(in_a_real) * DW'(in_b_real);
      p_ii_r <= DW'(in_a_imag) * DW'(in_b_imag);
      p_ri_r <= DW'(in_a_real) * DW'(in_b_imag);
      p_ir_r <= DW'(in_a_imag) * DW'(in_b_real);
      p_bb_r <= DW'(in_b_real) * DW'(in_b_real);
      p_cc_r <= DW'(in_b_imag) * DW'(in_b_imag);
      if (in_cmd == CMD_SUB) begin
        s_re_r <= (WB+1)'(in_a_real) - (WB+1)'(in_b_real);
        s_im_r <= (WB+1)'(in_a_imag) - (WB+1)'(in_b_imag);
      end else begin
        s_re_r <= (WB+1)'(in_a_real) + (WB+1)'(in_b_real);
        s_im_r <= (WB+1)'(in_a_imag) + (WB+1)'(in_b_imag);
      end
    end
  end

  // stage 2: pick the sums that the operation needs
  always_comb begin
    case (cmd1_r)
      CMD_MUL: begin
        t_re_nxt = SW'(p_rr_r) - SW'(p_ii_r);
        t_im_nxt = SW'(p_ri_r) + SW'(p_ir_r);
      end
      CMD_DIV: begin
        t_re_nxt = SW'(p_rr_r) + SW'(p_ii_r);
        t_im_nxt = SW'(p_ir_r) - SW'(p_ri_r);
      end
      default: begin
        t_re_nxt = SW'(s_re_r);
        t_im_nxt = SW'(s_im_r);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en2 && v1_r) begin
      cmd2_r <= cmd1_r;
      dz2_r  <= dz1_r;
      t_re_r <= t_re_nxt;
      t_im_r <= t_im_nxt;
      z2_r   <= DW'($unsigned(p_bb_r) + $unsigned(p_cc_r));
    end
  end

  // stage 3
  assign nm_re = SW'(0) - t_re_r;
  assign nm_im = SW'(0) - t_im_r;

  always_ff @(posedge clk) begin
    if (en3 && v2_r) begin
      cmd3_r   <= cmd2_r;
      dz3_r    <= dz2_r;
      z3_r     <= z2_r;
      neg_re_r <= t_re_r[SW-1];
      neg_im_r <= t_im_r[SW-1];
      mag_re_r <= t_re_r[SW-1] ? nm_re[DW-1:0] : t_re_r[DW-1:0];
      mag_im_r <= t_im_r[SW-1] ? nm_im[DW-1:0] : t_im_r[DW-1:0];
    end
  end

  // stage 4: finish add, sub and mul; set up the divide or flag divide by zero
  assign n_re  = NW'(mag_re_r) << FB;
  assign n_im  = NW'(mag_im_r) << FB;
  assign hi_re = n_re[NW-1:QB];
  assign hi_im = n_im[NW-1:QB];
  assign sre   = sat_word(neg_re_r, (cmd3_r == CMD_MUL) ? (mag_re_r >> FB) : mag_re_r);
  assign sim   = sat_word(neg_im_r, (cmd3_r == CMD_MUL) ? (mag_im_r >> FB) : mag_im_r);

  always_comb begin
    l4_nxt        = '0;
    l4_nxt.den    = z3_r;
    l4_nxt.neg_re = neg_re_r;
    l4_nxt.neg_im = neg_im_r;
    if (cmd3_r != CMD_DIV) begin
      l4_nxt.res_re = sre.val;
      l4_nxt.res_im = sim.val;
      l4_nxt.status = (sre.ovf || sim.ovf) ? ST_OVF : ST_OK;
    end else if (dz3_r) begin
      l4_nxt.status = ST_DZ;
    end else begin
      l4_nxt.div    = 1'b1;
      l4_nxt.big_re = DW'(hi_re) >= z3_r;
      l4_nxt.big_im = DW'(hi_im) >= z3_r;
      l4_nxt.rem_re = l4_nxt.big_re ? '0 : DW'(hi_re);
      l4_nxt.rem_im = l4_nxt.big_im ? '0 : DW'(hi_im);
      l4_nxt.num_re = n_re[QB-1:0];
      l4_nxt.num_im = n_im[QB-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en4 && v3_r) begin
      l4_r <= l4_nxt;
    end
  end

  assign out_valid = v4_r;
  assign out_data  = l4_r;

endmodule

[rtl/core/cau_div_cell.sv]
module cau_div_cell
  import cau_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  input  lane_t in_data,
  output logic  out_valid,
  input  logic  out_ready,
  output lane_t out_data
);

  logic          valid_r;
  lane_t         data_r, data_nxt;
  logic [DW:0]   r2_re, r2_im, df_re, df_im;
  logic          ge_re, ge_im;

  // one restoring step per lane: shift in a numerator bit, try the divisor
  assign r2_re = {in_data.rem_re, in_data.num_re[QB-1]};
  assign r2_im = {in_data.rem_im, in_data.num_im[QB-1]};
  assign df_re = r2_re - {1'b0, in_data.den};
  assign df_im = r2_im - {1'b0, in_data.den};
  assign ge_re = r2_re >= {1'b0, in_data.den};
  assign ge_im = r2_im >= {1'b0, in_data.den};

  always_comb begin
    data_nxt        = in_data;
    data_nxt.rem_re = ge_re ? df_re[DW-1:0] : r2_re[DW-1:0];
    data_nxt.rem_im = ge_im ? df_im[DW-1:0] : r2_im[DW-1:0];
    data_nxt.num_re = {in_data.num_re[QB-2:0], ge_re};
    data_nxt.num_im = {in_data.num_im[QB-2:0], ge_im};
  end

  assign in_ready = !valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data_r <= data_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

[rtl/core/cau_tail.sv]
`include "complex_arith_unit_core_macros.svh"

module cau_tail
  import cau_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  lane_t         in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [WB-1:0] out_real,
  output logic [WB-1:0] out_imag,
  output logic [1:0]    out_status
);

  logic          out_valid_r;
  logic [WB-1:0] re_r, im_r, re_nxt, im_nxt;
  logic [1:0]    st_r, st_nxt;
  sat_t          qre, qim;

  // saturate the quotients and apply the signs
  assign qre = sat_word(in_data.neg_re, in_data.big_re ? '1 : DW'(in_data.num_re));
  assign qim = sat_word(in_data.neg_im, in_data.big_im ? '1 : DW'(in_data.num_im));

  always_comb begin
    if (in_data.div) begin
      re_nxt = qre.val;
      im_nxt = qim.val;
      st_nxt = (qre.ovf || qim.ovf) ? ST_OVF : ST_OK;
    end else begin
      re_nxt = in_data.res_re;
      im_nxt = in_data.res_im;
      st_nxt = in_data.status;
    end
  end

  // output register
  assign in_ready = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_ready) begin
      out_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      re_r <= re_nxt;
      im_r <= im_nxt;
      st_r <= st_nxt;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_real   = re_r;
  assign out_imag   = im_r;
  assign out_status = st_r;

  // a quotient past the chain's reach must come out saturated
  `CAU_ASSERT_NXT(a_big_sat, in_valid && in_ready && in_data.div && in_data.big_re, out_status == ST_OVF, "quotient overflow not flagged")

endmodule

[tb/complex_arith_unit_core_tb.sv]
module complex_arith_unit_core_tb;
  import cau_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [1:0]           cmd;
    logic signed [WB-1:0] ar, ai, br, bi;
  } op_item_t;

  typedef struct {
    logic signed [WB-1:0] re, im;
    logic [1:0]           status;
  } cplx_res_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [1:0]           in_cmd = CMD_ADD;
  logic signed [WB-1:0] in_a_real = '0, in_a_imag = '0, in_b_real = '0, in_b_imag = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic signed [WB-1:0] out_real, out_imag;
  logic [1:0]           out_status;

  op_item_t  pending_ops[$];
  cplx_res_t expected_res[$];
  int        fail_cnt = 0;
  int        cycle_cnt = 0;
  bit        stim_done = 1'b0;

  complex_arith_unit_core u_top (.*);

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // saturate a wide signed value to a word, flagging overflow
  function automatic logic signed [WB-1:0] clamp_word(input logic signed [127:0] v,
                                                    inout logic ovf);
    if (v > 128'sd2147483647) begin
      ovf = 1'b1;
      return W_MAX;
    end
    if (v < -128'sd2147483648) begin
      ovf = 1'b1;
      return W_MIN;
    end
    return v[WB-1:0];
  endfunction

  // arithmetic shift that truncates toward zero
  function automatic logic signed [127:0] shr_trunc(input logic signed [127:0] v);
    logic signed [127:0] m;
    m = (v < 0) ? -v : v;
    m = m >>> FB;
    return (v < 0) ? -m : m;
  endfunction

  function automatic cplx_res_t complex_result(input op_item_t op);
    logic signed [127:0] ar, ai, br, bi, re, im, z;
    logic                ovf;
    cplx_res_t           r;
    ar = op.ar; ai = op.ai; br = op.br; bi = op.bi;
    ovf = 1'b0;
    case (op.cmd)
      CMD_ADD: begin re = ar + br; im = ai + bi; end
      CMD_SUB: begin re = ar - br; im = ai - bi; end
      CMD_MUL: begin
        re = shr_trunc(ar * br - ai * bi);
        im = shr_trunc(ar * bi + ai * br);
      end
      default: begin
        z = br * br + bi * bi;
        if (z == 0) begin
          r.re = '0; r.im = '0; r.status = ST_DZ;
          return r;
        end
        // SV signed division truncates toward zero
        re = ((ar * br + ai * bi) * 128'sd65536) / z;
        im = ((ai * br - ar * bi) * 128'sd65536) / z;
      end
    endcase
    r.re = clamp_word(re, ovf);
    r.im = clamp_word(im, ovf);
    r.status = ovf ? ST_OVF : ST_OK;
    return r;
  endfunction

  function automatic logic signed [WB-1:0] rand_part();
    case ($urandom_range(0, 9))
      0: return W_MAX;
      1: return W_MIN;
      2: return '0;
      3: return $signed(WB'($urandom_range(0, 8))) - 4;
      4, 5: return $signed(WB'($urandom_range(0, 32'h0003_ffff))) - 32'sh0002_0000;
      default: return $urandom;
    endcase
  endfunction

  task automatic add_op(input logic [1:0] c, input logic signed [WB-1:0] ar, ai, br, bi);
    op_item_t op;
    op.cmd = c; op.ar = ar; op.ai = ai; op.br = br; op.bi = bi;
    pending_ops.push_back(op);
  endtask

  // stimulus
  initial begin
    logic [1:0] c;
    for (int k = 0; k < 4; k++) begin
      c = 2'(k);
      add_op(c, W_MAX, W_MIN, W_MAX, W_MIN);
      add_op(c, W_MIN, W_MAX, W_MIN, W_MAX);
      add_op(c, 32'sh0001_0000, -32'sh0002_8000, 32'sh0003_0000, 32'sh0000_4000);
      add_op(c, -1, 1, -1, 1);
    end
    add_op(CMD_DIV, 32'sh0005_0000, 32'sh0001_0000, '0, '0);
    add_op(CMD_DIV, '0, '0, '0, '0);
    add_op(CMD_DIV, W_MAX, W_MAX, 1, 0);
    add_op(CMD_DIV, W_MIN, -1, 0, 1);
    add_op(CMD_MUL, W_MIN, 0, W_MIN, 0);
    add_op(CMD_SUB, 0, W_MIN, 0, 1);
    add_op(CMD_DIV, 32'sh7fff_0000, -3, -32'sh0000_8000, 32'sh0000_0001);
    for (int n = 0; n < 1250; n++)
      add_op(2'($urandom), rand_part(), rand_part(), rand_part(), rand_part());
    stim_done = 1'b1;
  end

  // reset, then idling policy runs in driver and monitor
  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
  end

  function automatic bit idle_now();
    // no idling during a long stretch in the middle of the run
    if (cycle_cnt > 500 && cycle_cnt < 1000) return 1'b0;
    return $urandom_range(0, 99) < 27;
  endfunction

  // driver
  always @(posedge clk) begin
    op_item_t op;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        expected_res.push_back(complex_result(pending_ops.pop_front()));
      end
      if (!in_valid || in_ready) begin
        if (pending_ops.size() > 0 && !idle_now()) begin
          op = pending_ops[0];
          in_valid  <= 1'b1;
          in_cmd    <= op.cmd;
          in_a_real <= op.ar;
          in_a_imag <= op.ai;
          in_b_real <= op.br;
          in_b_imag <= op.bi;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    cplx_res_t e;
    cycle_cnt <= cycle_cnt + 1;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_res.size() == 0) begin
          $error("unexpected item: real %0d imag %0d status %0d",
                 out_real, out_imag, out_status);
          fail_cnt++;
        end else begin
          e = expected_res.pop_front();
          if (out_real !== e.re) begin
            $error("out_real expected %0d actual %0d", e.re, out_real);
            fail_cnt++;
          end
          if (out_imag !== e.im) begin
            $error("out_imag expected %0d actual %0d", e.im, out_imag);
            fail_cnt++;
          end
          if (out_status !== e.status) begin
            $error("out_status expected %0d actual %0d", e.status, out_status);
            fail_cnt++;
          end
        end
      end
      out_ready <= !idle_now();
    end
  end

  // end of run
  initial begin
    wait (rst_n && stim_done);
    while ((pending_ops.size() != 0 || in_valid || expected_res.size() != 0)
           && cycle_cnt < 200000)
      @(posedge clk);
    repeat (60) @(posedge clk);
    if (cycle_cnt >= 200000 || fail_cnt != 0 || expected_res.size() != 0) begin
      $display("SCOREBOARD MISMATCH");
    end else begin
      $display("SCOREBOARD CLEAN");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+rtl/core
rtl/core/cau_pkg.sv
rtl/core/cau_front.sv
rtl/core/cau_div_cell.sv
rtl/core/cau_tail.sv
rtl/core/complex_arith_unit_core.sv
tb/complex_arith_unit_core_tb.sv
